FILE: rtl/core/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// shared types and constants of the led line color scaler
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int MaxSource = 256;
  localparam int MaxLeds   = 1024;
  localparam int FracBits  = 8;

  localparam int PosW  = 10;
  localparam int ChanW = 8;
  localparam int ColorW = 3 * ChanW;
  localparam int SlotW = $clog2(MaxSource);
  localparam int SrcCntW = 9;
  localparam int LedCntW = 11;
  localparam int NumW = PosW + SlotW;
  localparam int DenW = PosW;
  localparam int QuoW = SlotW + FracBits;
  localparam int PAddrW = 3;
  localparam int PDataW = 32;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindPixel = 1'b1;

  localparam logic RegSourceCount = 1'b0;
  localparam logic RegLedCount    = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [PosW-1:0]  position;
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
  } req_t;

  typedef struct packed {
    logic [PosW-1:0]  led_index;
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
  } res_t;

  typedef struct packed {
    logic              kind;
    logic [PosW-1:0]   pos;
    logic [ColorW-1:0] color;
    logic              sel_div;
    logic              upscale;
    logic [SlotW-1:0]  preset;
  } tag_t;

endpackage

FILE: rtl/core/lcs_div.sv
// ----------------------------------------------------------------------------
// lcs_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module lcs_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [lcs_pkg::NumW-1:0] num_i,
  input  logic [lcs_pkg::DenW-1:0] den_i,
  input  lcs_pkg::tag_t          tag_i,
  output logic                   valid_o,
  output logic [lcs_pkg::QuoW-1:0] quo_o,
  output lcs_pkg::tag_t          tag_o
);
  import lcs_pkg::*;

  logic              vld  [QuoW+1];
  logic [DenW-1:0]   rem  [QuoW+1];
  logic [QuoW-1:0]   work [QuoW+1];
  logic [DenW-1:0]   den  [QuoW+1];
  tag_t              tag  [QuoW+1];

  assign vld[0]  = valid_i;
  assign rem[0]  = num_i[NumW-1:SlotW];
  assign work[0] = {num_i[SlotW-1:0], {FracBits{1'b0}}};
  assign den[0]  = den_i;
  assign tag[0]  = tag_i;

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    logic [DenW:0] trial;
    logic          ge;
    assign trial = {rem[k], work[k][QuoW-1]};
    assign ge    = trial >= {1'b0, den[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem[k+1]  <= ge ? DenW'(trial - {1'b0, den[k]}) : trial[DenW-1:0];
      work[k+1] <= {work[k][QuoW-2:0], ge};
      den[k+1]  <= den[k];
      tag[k+1]  <= tag[k];
    end
  end

  assign valid_o = vld[QuoW];
  assign quo_o   = work[QuoW];
  assign tag_o   = tag[QuoW];

endmodule

FILE: rtl/core/led_line_color_scaler.sv
// ----------------------------------------------------------------------------
// led_line_color_scaler
// resamples a line of source colors onto an led strip of another length
// ----------------------------------------------------------------------------
// One request is taken every clock cycle; busy stays low. Each pixel request
// passes in order through the input register, the 16-stage divider that
// finds the source slot and blend fraction, the line store read, the blend
// multiply and the output register. Load requests and pixel requests at or
// beyond the led count give no result. The result strobe is high for one
// cycle and cannot be held off.
module led_line_color_scaler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  lcs_pkg::req_t              req_i,
  output logic                       res_valid_o,
  output lcs_pkg::res_t              res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lcs_pkg::PAddrW-1:0] paddr,
  input  logic [lcs_pkg::PDataW-1:0] pwdata,
  output logic [lcs_pkg::PDataW-1:0] prdata,
  output logic                       pready
);
  import lcs_pkg::*;

  logic [SrcCntW-1:0] src_cnt_q;
  logic [LedCntW-1:0] led_cnt_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_cnt_q <= SrcCntW'(1);
      led_cnt_q <= LedCntW'(1);
    end else if (cfg_we) begin
      if (paddr[2] == RegSourceCount) begin
        src_cnt_q <= pwdata[SrcCntW-1:0];
      end else begin
        led_cnt_q <= pwdata[LedCntW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == RegSourceCount) ? PDataW'(src_cnt_q) : PDataW'(led_cnt_q);

  // effective counts
  logic [SrcCntW-1:0] s_cnt;
  logic [LedCntW-1:0] l_cnt;
  always_comb begin
    if (src_cnt_q == '0) s_cnt = SrcCntW'(1);
    else if (int'(src_cnt_q) > MaxSource) s_cnt = SrcCntW'(MaxSource);
    else s_cnt = src_cnt_q;
    if (led_cnt_q == '0) l_cnt = LedCntW'(1);
    else if (int'(led_cnt_q) > MaxLeds) l_cnt = LedCntW'(MaxLeds);
    else l_cnt = led_cnt_q;
  end

  // request classification
  logic         drop, single, equal;
  logic [SlotW-1:0] s_m1;
  tag_t         tag_d;
  assign drop   = (req_i.kind == KindPixel) && ({1'b0, req_i.position} >= l_cnt);
  assign single = (s_cnt == SrcCntW'(1)) || (l_cnt == LedCntW'(1));
  assign equal  = (l_cnt == LedCntW'(s_cnt));
  assign s_m1   = SlotW'(s_cnt - SrcCntW'(1));

  always_comb begin
    tag_d.kind    = req_i.kind;
    tag_d.pos     = req_i.position;
    tag_d.color   = {req_i.red_in, req_i.green_in, req_i.blue_in};
    tag_d.sel_div = !single && !equal;
    tag_d.upscale = l_cnt > LedCntW'(s_cnt);
    tag_d.preset  = single ? '0 : req_i.position[SlotW-1:0];
  end

  logic            in_vld_q;
  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  tag_t            tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy && !drop;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= NumW'(req_i.position) * NumW'(s_m1);
    den_q <= DenW'(l_cnt - LedCntW'(1));
    tag_q <= tag_d;
  end

  logic            dv_vld;
  logic [QuoW-1:0] quo;
  tag_t            dv_tag;

  lcs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .tag_i   (tag_q),
    .valid_o (dv_vld),
    .quo_o   (quo),
    .tag_o   (dv_tag)
  );

  // line store access
  logic [SlotW-1:0]    idx;
  logic [FracBits-1:0] frac;
  assign idx  = dv_tag.sel_div ? quo[QuoW-1:FracBits] : dv_tag.preset;
  assign frac = (dv_tag.sel_div && dv_tag.upscale) ? quo[FracBits-1:0] : '0;

  logic [ColorW-1:0]   line_mem [MaxSource];
  logic [ColorW-1:0]   rd_a_q, rd_b_q;
  logic                m_vld_q;
  logic [PosW-1:0]     m_pos_q;
  logic [FracBits-1:0] m_frac_q;

  always_ff @(posedge clk_i) begin
    if (dv_vld && dv_tag.kind == KindLoad && int'(dv_tag.pos) < MaxSource) begin
      line_mem[dv_tag.pos[SlotW-1:0]] <= dv_tag.color;
    end
    rd_a_q   <= line_mem[idx];
    rd_b_q   <= line_mem[SlotW'(idx + SlotW'(1))];
    m_pos_q  <= dv_tag.pos;
    m_frac_q <= frac;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= dv_vld && dv_tag.kind == KindPixel;
    end
  end

  // blend products
  logic [FracBits:0]         inv;
  logic [ChanW+FracBits:0]   pa_q [3];
  logic [ChanW+FracBits:0]   pb_q [3];
  logic                      b_vld_q;
  logic [PosW-1:0]           b_pos_q;

  assign inv = (FracBits+1)'(1 << FracBits) - {1'b0, m_frac_q};

  for (genvar c = 0; c < 3; c++) begin : g_chan
    always_ff @(posedge clk_i) begin
      pa_q[c] <= (ChanW+FracBits+1)'(rd_a_q[c*ChanW +: ChanW]) * (ChanW+FracBits+1)'(inv);
      if (m_frac_q == '0) begin
        pb_q[c] <= '0;
      end else begin
        pb_q[c] <= (ChanW+FracBits+1)'(rd_b_q[c*ChanW +: ChanW])
                 * (ChanW+FracBits+1)'(m_frac_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    b_pos_q <= m_pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= m_vld_q;
    end
  end

  // sum and output register
  logic [ChanW+FracBits+1:0] sum [3];
  res_t                      res_d, res_q;
  logic                      res_vld_q;

  for (genvar c = 0; c < 3; c++) begin : g_sum
    assign sum[c] = {1'b0, pa_q[c]} + {1'b0, pb_q[c]};
  end

  always_comb begin
    res_d.led_index = b_pos_q;
    res_d.red_out   = sum[2][FracBits +: ChanW];
    res_d.green_out = sum[1][FracBits +: ChanW];
    res_d.blue_out  = sum[0][FracBits +: ChanW];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= b_vld_q;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule
